@@ rtl/mec_pkg.sv @@
// Shared types, constants and helpers for the escape-time counter.
// Used by mec_mul, mec_iter and mandelbrot_escape_counter_core; no dependencies.
package mec_pkg;

    localparam int INDEX_BITS = 10;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 26;

    localparam int COORD_W  = 32;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SQ_W     = PROD_W - 1;
    localparam int STEP_W   = 31;
    localparam int MAXIT_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int IN_W         = 2 * INDEX_BITS;
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W        = 2 * INDEX_BITS + COUNT_BITS;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // |z|^2 bound of 4.0 at full product width.
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X    = 3'd0,
        REG_MIN_Y    = 3'd1,
        REG_STEP_X   = 3'd2,
        REG_STEP_Y   = 3'd3,
        REG_MAX_ITER = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_CYW,
        ST_XY,
        ST_UPD,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
        logic [MAXIT_W-1:0]        max_iter;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [INDEX_BITS-1:0] col;
        logic [INDEX_BITS-1:0] row;
    } t_res;

    // Clamp a wide signed value to the signed 32-bit coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        hi = (PROD_W+1)'(2147483647);
        lo = -hi - (PROD_W+1)'(1);
        if (v > hi) begin
            return COORD_W'(hi);
        end else if (v < lo) begin
            return COORD_W'(lo);
        end
        return COORD_W'(v);
    endfunction

endpackage

@@ rtl/mec_mul.sv @@
// Registered signed 32x32 multiplier shared by all products of one pixel.
// Depends on mec_pkg for widths.
module mec_mul (
    input  logic                                 i_clk,
    input  logic signed [mec_pkg::COORD_W-1:0]   i_a,
    input  logic signed [mec_pkg::COORD_W-1:0]   i_b,
    output logic signed [mec_pkg::PROD_W-1:0]    o_prod
);

    logic signed [mec_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/mec_iter.sv @@
// Sequencer and datapath for one pixel: maps row/col to c and runs z = z^2 + c.
// Depends on mec_pkg and on the shared multiplier mec_mul.
module mec_iter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mec_pkg::t_cfg                      i_cfg,
    input  logic                               i_start_valid,
    output logic                               o_start_ready,
    input  logic [mec_pkg::INDEX_BITS-1:0]     i_row,
    input  logic [mec_pkg::INDEX_BITS-1:0]     i_col,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output mec_pkg::t_res                      o_res
);

    mec_pkg::t_state r_state, n_state;

    logic [mec_pkg::INDEX_BITS-1:0]        r_row, r_col;
    logic signed [mec_pkg::COORD_W-1:0]    r_cx, r_cy, r_x, r_y;
    logic [mec_pkg::SQ_W-1:0]              r_xx, r_yy;
    logic signed [mec_pkg::PROD_W-1:0]     r_diff;
    logic [mec_pkg::MAXIT_W-1:0]           r_iter;

    logic signed [mec_pkg::COORD_W-1:0]    mul_a, mul_b;
    logic signed [mec_pkg::PROD_W-1:0]     prod;
    logic [mec_pkg::PROD_W-1:0]            mag;
    logic                                  escaped;
    logic                                  last_iter;

    mec_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign mag       = mec_pkg::PROD_W'(r_xx) + mec_pkg::PROD_W'(prod[mec_pkg::SQ_W-1:0]);
    assign escaped   = mag > mec_pkg::ESCAPE_LIMIT;
    assign last_iter = (r_iter + 1'b1) == i_cfg.max_iter;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = r_x;
        mul_b = r_y;
        case (r_state)
            mec_pkg::ST_CX: begin
                mul_a = $signed(mec_pkg::COORD_W'(r_col));
                mul_b = $signed(mec_pkg::COORD_W'(i_cfg.step_x));
            end
            mec_pkg::ST_CY: begin
                mul_a = $signed(mec_pkg::COORD_W'(r_row));
                mul_b = $signed(mec_pkg::COORD_W'(i_cfg.step_y));
            end
            mec_pkg::ST_SQX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            mec_pkg::ST_SQY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_y;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mec_pkg::ST_IDLE: begin
                if (i_start_valid) begin
                    n_state = (i_cfg.max_iter == '0) ? mec_pkg::ST_DONE : mec_pkg::ST_CX;
                end
            end
            mec_pkg::ST_CX:  n_state = mec_pkg::ST_CY;
            mec_pkg::ST_CY:  n_state = mec_pkg::ST_CYW;
            mec_pkg::ST_CYW: n_state = mec_pkg::ST_XY;
            mec_pkg::ST_XY:  n_state = mec_pkg::ST_UPD;
            mec_pkg::ST_UPD: n_state = mec_pkg::ST_SQX;
            mec_pkg::ST_SQX: n_state = mec_pkg::ST_SQY;
            mec_pkg::ST_SQY: n_state = mec_pkg::ST_CMP;
            mec_pkg::ST_CMP: begin
                n_state = (escaped || last_iter) ? mec_pkg::ST_DONE : mec_pkg::ST_XY;
            end
            mec_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = mec_pkg::ST_IDLE;
                end
            end
            default: n_state = mec_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mec_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mec_pkg::ST_IDLE: begin
                r_row  <= i_row;
                r_col  <= i_col;
                r_x    <= '0;
                r_y    <= '0;
                r_xx   <= '0;
                r_yy   <= '0;
                r_iter <= '0;
            end
            mec_pkg::ST_CY: begin
                r_cx <= mec_pkg::sat_coord((mec_pkg::PROD_W+1)'(prod)
                                           + (mec_pkg::PROD_W+1)'(i_cfg.min_x));
            end
            mec_pkg::ST_CYW: begin
                r_cy <= mec_pkg::sat_coord((mec_pkg::PROD_W+1)'(prod)
                                           + (mec_pkg::PROD_W+1)'(i_cfg.min_y));
            end
            mec_pkg::ST_XY: begin
                r_diff <= $signed({1'b0, r_xx}) - $signed({1'b0, r_yy});
            end
            mec_pkg::ST_UPD: begin
                // Arithmetic shifts round toward minus infinity; x*y >> (F-1) is 2xy.
                r_y <= mec_pkg::sat_coord((mec_pkg::PROD_W+1)'(prod >>> (mec_pkg::FRAC_BITS - 1))
                                          + (mec_pkg::PROD_W+1)'(r_cy));
                r_x <= mec_pkg::sat_coord((mec_pkg::PROD_W+1)'(r_diff >>> mec_pkg::FRAC_BITS)
                                          + (mec_pkg::PROD_W+1)'(r_cx));
            end
            mec_pkg::ST_SQY: begin
                r_xx <= prod[mec_pkg::SQ_W-1:0];
            end
            mec_pkg::ST_CMP: begin
                r_yy <= prod[mec_pkg::SQ_W-1:0];
                if (!escaped) begin
                    r_iter <= r_iter + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_start_ready = (r_state == mec_pkg::ST_IDLE);
    assign o_res_valid   = (r_state == mec_pkg::ST_DONE);
    assign o_res.row     = r_row;
    assign o_res.col     = r_col;
    assign o_res.count   = mec_pkg::COUNT_BITS'(r_iter);

endmodule

@@ rtl/mandelbrot_escape_counter_core.sv @@
// Top level of the escape-time counter: configuration registers, stream ports
// and output register. Depends on mec_pkg and mec_iter.
//
//  Channel   Direction  Signals                          Payload
//  s (pixel) in         i_s_tvalid/o_s_tready/i_s_tdata  row, col
//  m (count) out        o_m_tvalid/i_m_tready/o_m_tdata  row_out, col_out, iteration_count
//  cfg       in         i_cfg_we/i_cfg_index/i_cfg_wdata register write
//
// A pixel runs the setup states CX, CY and CYW, then XY, UPD, SQX, SQY and CMP for
// each iteration, all on the one shared multiplier (products col*step_x, row*step_y,
// then x*y, x*x and y*y per iteration); the result then moves to the output register.
// Reset is synchronous and active low; it loads the default view registers.
// The next pixel is taken once the result has moved to the output register,
// so a stalled output holds at most one finished pixel plus one in flight.
module mandelbrot_escape_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mec_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // row, col
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mec_pkg::OUT_TDATA_W-1:0]     o_m_tdata,   // row_out, col_out, iteration_count
    input  logic                                i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mec_pkg::CFG_W-1:0]           i_cfg_wdata
);

    mec_pkg::t_cfg r_cfg;
    mec_pkg::t_res r_out;
    logic          r_out_valid;

    mec_pkg::t_res iter_res;
    logic          iter_valid;
    logic          iter_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x    <= -mec_pkg::COORD_W'(134217728);
            r_cfg.min_y    <= -mec_pkg::COORD_W'(100663296);
            r_cfg.step_x   <= mec_pkg::STEP_W'(196608);
            r_cfg.step_y   <= mec_pkg::STEP_W'(196608);
            r_cfg.max_iter <= mec_pkg::MAXIT_W'(256);
        end else if (i_cfg_we) begin
            case (mec_pkg::t_reg_idx'(i_cfg_index))
                mec_pkg::REG_MIN_X:    r_cfg.min_x    <= $signed(i_cfg_wdata);
                mec_pkg::REG_MIN_Y:    r_cfg.min_y    <= $signed(i_cfg_wdata);
                mec_pkg::REG_STEP_X:   r_cfg.step_x   <= i_cfg_wdata[mec_pkg::STEP_W-1:0];
                mec_pkg::REG_STEP_Y:   r_cfg.step_y   <= i_cfg_wdata[mec_pkg::STEP_W-1:0];
                mec_pkg::REG_MAX_ITER: r_cfg.max_iter <= i_cfg_wdata[mec_pkg::MAXIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mec_iter u_iter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start_valid (i_s_tvalid),
        .o_start_ready (o_s_tready),
        .i_row         (i_s_tdata[mec_pkg::INDEX_BITS-1:0]),
        .i_col         (i_s_tdata[2*mec_pkg::INDEX_BITS-1:mec_pkg::INDEX_BITS]),
        .o_res_valid   (iter_valid),
        .i_res_ready   (iter_ready),
        .o_res         (iter_res)
    );

    assign iter_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (iter_ready) begin
            r_out_valid <= iter_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (iter_ready && iter_valid) begin
            r_out <= iter_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mec_pkg::OUT_TDATA_W'(r_out);

endmodule
